// ===== rtl/cvs_pkg.sv =====
// Package of shared types and constants for the streaming 2-D convolution block.
package cvs_pkg;

  localparam int MAX_IMAGE_WIDTH  = 256;
  localparam int MAX_KERNEL_SIZE  = 8;
  localparam int SAMPLE_BITS      = 16;
  localparam int MAX_IMAGE_HEIGHT = 4096;
  localparam int KERNEL_DEPTH     = 64;
  localparam int SUM_BITS         = 40;
  localparam int ROW_BITS         = 12;
  localparam int COL_BITS         = 8;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_KERNEL_WIDTH  = 2'd2,
    REG_KERNEL_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MAC  = 2'd1,
    ST_LAST = 2'd2,
    ST_OUT  = 2'd3
  } back_state_t;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] out_value;
    logic [ROW_BITS-1:0]        out_row;
    logic [COL_BITS-1:0]        out_col;
    logic                       last_of_image;
  } out_item_t;

  // Job passed from the front end to the MAC engine
  typedef struct packed {
    logic [2:0]          slot;    // line slot of current row
    logic [11:0]         col;     // column of current sample
    logic [3:0]          kw;
    logic [3:0]          kh;
    logic [ROW_BITS-1:0] orow;
    logic [COL_BITS-1:0] ocol;
    logic                last;
  } job_t;

endpackage

// ===== rtl/cvs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cvs_front.sv =====
// Front end: registers, position tracking, store writes and job issue.
module cvs_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [12:0]             cfg_data,
  input  logic                    push,
  output logic                    full,
  input  cvs_pkg::in_item_t       in_item,
  input  logic                    busy,
  output logic                    job_valid,
  output cvs_pkg::job_t           job,
  output logic                    kwe,
  output logic [5:0]              kwaddr,
  output logic [cvs_pkg::SAMPLE_BITS-1:0] kwdata,
  output logic                    lwe,
  output logic [$clog2(cvs_pkg::MAX_KERNEL_SIZE*cvs_pkg::MAX_IMAGE_WIDTH)-1:0] lwaddr,
  output logic [cvs_pkg::SAMPLE_BITS-1:0] lwdata
);

  localparam int CB = $clog2(cvs_pkg::MAX_IMAGE_WIDTH);
  localparam int SB = $clog2(cvs_pkg::MAX_KERNEL_SIZE);

  logic [8:0]  image_width;
  logic [12:0] image_height;
  logic [3:0]  kernel_width;
  logic [3:0]  kernel_height;
  logic [5:0]  weight_position;
  logic [11:0] image_row;
  logic [11:0] image_col;
  logic [12:0] w_c, h_c;
  logic [3:0]  kw_c, kh_c;
  logic        acc;
  logic [11:0] c;

  assign cfg_ready = 1'b1;
  assign full      = busy | job_valid;
  assign acc       = push & ~full;

  // Clamp dimensions
  always_comb begin
    w_c  = (image_width == '0) ? 13'd1 :
           ({4'd0, image_width} > 13'(cvs_pkg::MAX_IMAGE_WIDTH)) ?
             13'(cvs_pkg::MAX_IMAGE_WIDTH) : {4'd0, image_width};
    h_c  = (image_height == '0) ? 13'd1 :
           (image_height > 13'(cvs_pkg::MAX_IMAGE_HEIGHT)) ?
             13'(cvs_pkg::MAX_IMAGE_HEIGHT) : image_height;
    kw_c = (kernel_width == '0) ? 4'd1 :
           (kernel_width > 4'(cvs_pkg::MAX_KERNEL_SIZE)) ? 4'(cvs_pkg::MAX_KERNEL_SIZE)
                                                          : kernel_width;
    kh_c = (kernel_height == '0) ? 4'd1 :
           (kernel_height > 4'(cvs_pkg::MAX_KERNEL_SIZE)) ? 4'(cvs_pkg::MAX_KERNEL_SIZE)
                                                           : kernel_height;
    c    = image_col & 12'(cvs_pkg::MAX_IMAGE_WIDTH - 1);
  end

  // Store writes
  assign kwe    = acc & ~in_item.mode;
  assign kwaddr = weight_position;
  assign kwdata = in_item.sample_value;
  assign lwe    = acc & in_item.mode;
  assign lwaddr = {image_row[SB-1:0], c[CB-1:0]};
  assign lwdata = in_item.sample_value;

  // Configuration, position and job register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 9'd256;
      image_height    <= 13'd256;
      kernel_width    <= 4'd3;
      kernel_height   <= 4'd3;
      weight_position <= '0;
      image_row       <= '0;
      image_col       <= '0;
      job_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cvs_pkg::cfg_reg_t'(cfg_index))
          cvs_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[8:0];
          cvs_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          cvs_pkg::REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
          cvs_pkg::REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
          default: ;
        endcase
      end
      job_valid <= 1'b0;
      if (acc && !in_item.mode) begin
        weight_position <= weight_position + 6'd1;
        image_row       <= '0;
        image_col       <= '0;
      end else if (acc) begin
        weight_position <= '0;
        if ({4'd0, kw_c} <= w_c && {9'd0, kh_c} <= h_c &&
            {1'b0, image_row} + 13'd1 >= {9'd0, kh_c} && c + 12'd1 >= {8'd0, kw_c}) begin
          job_valid <= 1'b1;
        end
        job.slot <= 3'(image_row[SB-1:0]);
        job.col  <= c;
        job.kw   <= kw_c;
        job.kh   <= kh_c;
        job.orow <= image_row - 12'(kh_c) + 12'd1;
        job.ocol <= 8'(c - 12'(kw_c) + 12'd1);
        job.last <= ({1'b0, image_row} == h_c - 13'd1) && ({1'b0, c} == w_c - 13'd1);
        if ({1'b0, image_col} + 13'd1 >= w_c) begin
          image_col <= '0;
          image_row <= ({1'b0, image_row} + 13'd1 >= h_c) ? '0 : image_row + 12'd1;
        end else begin
          image_col <= image_col + 12'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/cvs_back.sv =====
// Back end: shared multiply-accumulate over the window and result register.
module cvs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  cvs_pkg::job_t          job,
  output logic                   busy,
  output logic [5:0]             kraddr,
  input  logic [cvs_pkg::SAMPLE_BITS-1:0] krdata,
  output logic [$clog2(cvs_pkg::MAX_KERNEL_SIZE*cvs_pkg::MAX_IMAGE_WIDTH)-1:0] lraddr,
  input  logic [cvs_pkg::SAMPLE_BITS-1:0] lrdata,
  output logic                   empty,
  input  logic                   pop,
  output cvs_pkg::out_item_t     out_item
);

  localparam int CB = $clog2(cvs_pkg::MAX_IMAGE_WIDTH);
  localparam int SB = $clog2(cvs_pkg::MAX_KERNEL_SIZE);
  localparam int PB = 2 * cvs_pkg::SAMPLE_BITS;

  cvs_pkg::back_state_t state, state_next;
  cvs_pkg::job_t        cur;
  logic [3:0]  m, n;
  logic        rd_valid, prod_valid;
  logic signed [PB-1:0] prod;
  logic signed [cvs_pkg::SUM_BITS-1:0] sum;
  logic        step, walk_done;
  logic [11:0] cc;
  logic [2:0]  rr;
  logic [7:0]  kidx;

  assign busy      = (state != cvs_pkg::ST_IDLE);
  assign empty     = (state != cvs_pkg::ST_OUT);
  assign step      = (state == cvs_pkg::ST_MAC);
  assign walk_done = (m == cur.kh - 4'd1) && (n == cur.kw - 4'd1);
  assign cc        = cur.col - {8'd0, n};
  assign rr        = cur.slot - m[2:0];
  assign kidx      = m * cur.kw + {4'd0, n};
  assign kraddr    = kidx[5:0];
  assign lraddr    = {rr[SB-1:0], cc[CB-1:0]};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cvs_pkg::ST_IDLE: if (job_valid) state_next = cvs_pkg::ST_MAC;
      cvs_pkg::ST_MAC:  if (walk_done) state_next = cvs_pkg::ST_LAST;
      cvs_pkg::ST_LAST: if (!rd_valid && !prod_valid) state_next = cvs_pkg::ST_OUT;
      cvs_pkg::ST_OUT:  if (pop) state_next = cvs_pkg::ST_IDLE;
      default:          state_next = cvs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk taps, read stores, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= step;
      prod_valid <= rd_valid;
    end
    prod <= $signed(lrdata) * $signed(krdata);
    if (state == cvs_pkg::ST_IDLE && job_valid) begin
      cur <= job;
      m   <= '0;
      n   <= '0;
      sum <= '0;
    end else begin
      if (step && !walk_done) begin
        if (n == cur.kw - 4'd1) begin
          n <= '0;
          m <= m + 4'd1;
        end else begin
          n <= n + 4'd1;
        end
      end
      if (prod_valid) sum <= sum + cvs_pkg::SUM_BITS'(prod);
    end
  end

  assign out_item.out_value     = sum;
  assign out_item.out_row       = cur.orow;
  assign out_item.out_col       = cur.ocol;
  assign out_item.last_of_image = cur.last;

endmodule

// ===== rtl/conv2d_valid_stream.sv =====
// Top level of the streaming valid-mode 2-D convolution block.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes image_width,
//   image_height, kernel_width, kernel_height; always ready, write only when idle.
//   Input queue side: push/full with in_item (mode 0 = weight, 1 = image sample).
//   Result queue side: empty/pop with out_item.
// Operation:
//   Weights, and samples that yield no output, leave the input open.
//   A sample that yields an output issues a job to the MAC engine; one
//   shared multiplier walks the kw*kh window through the store reads and
//   product register, and the result appears once that pipeline drains.
// Reset: registers return to 256x256 image, 3x3 kernel; position cleared.
//   Kernel and line stores are not cleared.
// Stall: a held result keeps the engine busy; full stays high from the
//   sample that starts a window until its result is popped.
module conv2d_valid_stream (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  cvs_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output cvs_pkg::out_item_t out_item
);

  localparam int LD = cvs_pkg::MAX_KERNEL_SIZE * cvs_pkg::MAX_IMAGE_WIDTH;

  logic                   busy, job_valid, kwe, lwe;
  cvs_pkg::job_t          job;
  logic [5:0]             kwaddr, kraddr;
  logic [$clog2(LD)-1:0]  lwaddr, lraddr;
  logic [cvs_pkg::SAMPLE_BITS-1:0] kwdata, krdata, lwdata, lrdata;

  cvs_front u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .push, .full,
    .in_item, .busy, .job_valid, .job, .kwe, .kwaddr, .kwdata, .lwe, .lwaddr, .lwdata
  );

  cvs_ram #(.WIDTH(cvs_pkg::SAMPLE_BITS), .DEPTH(cvs_pkg::KERNEL_DEPTH)) u_kram (
    .clk, .we(kwe), .waddr(kwaddr), .wdata(kwdata), .raddr(kraddr), .rdata(krdata)
  );

  cvs_ram #(.WIDTH(cvs_pkg::SAMPLE_BITS), .DEPTH(LD)) u_lram (
    .clk, .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(lraddr), .rdata(lrdata)
  );

  cvs_back u_back (
    .clk, .rst, .job_valid, .job, .busy, .kraddr, .krdata, .lraddr, .lrdata,
    .empty, .pop, .out_item
  );

`ifndef SYNTHESIS
  // Input is blocked while a job is pending
  a_full_job: assert property (@(posedge clk) disable iff (rst) job_valid |-> full)
    else $error("job pending but input open");
  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result dropped while stalled");
  // A result only appears after work on a job
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(busy))
    else $error("result without job");
`endif

endmodule

// ===== tb/tb_conv2d_valid_stream.sv =====
// Self-checking testbench for the streaming valid-mode 2-D convolution block.
`timescale 1ns / 100ps

module tb_conv2d_valid_stream;

  localparam int IDLE_WAIT   = 80;   // settle wait, sized for an 8x8 window
  localparam int HOLD_CYCLES = 700;  // long receiver hold-off
  localparam int ITEM_GOAL   = 650;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  cvs_pkg::cfg_reg_t   cfg_index;
  logic [12:0]         cfg_data;
  logic                push;
  logic                full;
  cvs_pkg::in_item_t   in_item;
  logic                empty;
  logic                pop;
  cvs_pkg::out_item_t  out_item;

  conv2d_valid_stream uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  // Own copy of the block state
  logic [8:0]         reg_width;
  logic [12:0]        reg_height;
  logic [3:0]         reg_kw;
  logic [3:0]         reg_kh;
  logic signed [15:0] kernel_mem [cvs_pkg::KERNEL_DEPTH];
  logic signed [15:0] line_mem [cvs_pkg::MAX_KERNEL_SIZE][cvs_pkg::MAX_IMAGE_WIDTH];
  int unsigned        wgt_pos;
  int unsigned        pos_row;
  int unsigned        pos_col;

  cvs_pkg::out_item_t conv_results_due[$];
  int        n_items;
  int        n_results;
  int        n_errors;
  int        n_phases;
  bit        calm;
  bit        hold_done;
  int        hold_left;

  // Directed stimulus row
  typedef struct {
    bit                 is_cfg;
    cvs_pkg::cfg_reg_t  idx;
    int                 data;
    cvs_pkg::in_item_t  it;
    bit                 typed;
    cvs_pkg::out_item_t res;
  } dir_row_t;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one transaction to the state copy; return 1 when a result is due
  function automatic bit conv_predict(cvs_pkg::in_item_t it, output cvs_pkg::out_item_t res);
    int unsigned w, h, kw, kh, r, c;
    logic signed [cvs_pkg::SUM_BITS-1:0] acc;
    bit hit;
    w  = clamp_dim(reg_width, cvs_pkg::MAX_IMAGE_WIDTH);
    h  = clamp_dim(reg_height, cvs_pkg::MAX_IMAGE_HEIGHT);
    kw = clamp_dim(reg_kw, cvs_pkg::MAX_KERNEL_SIZE);
    kh = clamp_dim(reg_kh, cvs_pkg::MAX_KERNEL_SIZE);
    res = '0;
    hit = 0;
    if (!it.mode) begin
      kernel_mem[wgt_pos] = it.sample_value;
      wgt_pos = (wgt_pos + 1) % cvs_pkg::KERNEL_DEPTH;
      pos_row = 0;
      pos_col = 0;
      return 0;
    end
    wgt_pos = 0;
    r = pos_row;
    c = pos_col % cvs_pkg::MAX_IMAGE_WIDTH;
    line_mem[r % cvs_pkg::MAX_KERNEL_SIZE][c] = it.sample_value;
    if (kw <= w && kh <= h && r + 1 >= kh && c + 1 >= kw) begin
      acc = '0;
      for (int m = 0; m < kh; m++)
        for (int n = 0; n < kw; n++)
          acc += cvs_pkg::SUM_BITS'(line_mem[(r - m) % cvs_pkg::MAX_KERNEL_SIZE][c - n]) *
                 cvs_pkg::SUM_BITS'(kernel_mem[(m * kw + n) % cvs_pkg::KERNEL_DEPTH]);
      res.out_value     = acc;
      res.out_row       = cvs_pkg::ROW_BITS'(r - (kh - 1));
      res.out_col       = cvs_pkg::COL_BITS'(c - (kw - 1));
      res.last_of_image = (r == h - 1 && c == w - 1);
      hit = 1;
    end
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
    return hit;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Offer one transaction; called on a falling edge, returns on a falling edge
  task automatic send_item(cvs_pkg::in_item_t it, bit typed = 0,
                           cvs_pkg::out_item_t res_typed = '0);
    cvs_pkg::out_item_t res;
    while (!calm && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    if (conv_predict(it, res)) conv_results_due.push_back(typed ? res_typed : res);
    n_items++;
    @(negedge clk);
  endtask

  // Wait until every result is in, then let the engine settle
  task automatic drain();
    push <= 1'b0;
    while (conv_results_due.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic cfg_write(cvs_pkg::cfg_reg_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 13'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cvs_pkg::REG_IMAGE_WIDTH:   reg_width  = 9'(val);
      cvs_pkg::REG_IMAGE_HEIGHT:  reg_height = 13'(val);
      cvs_pkg::REG_KERNEL_WIDTH:  reg_kw     = 4'(val);
      default:                    reg_kh     = 4'(val);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic cvs_pkg::in_item_t mk(bit mode, logic [15:0] v);
    cvs_pkg::in_item_t it;
    it.mode = mode;
    it.sample_value = v;
    return it;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cvs_pkg::out_item_t mk_res(longint v, int r, int c, bit l);
    cvs_pkg::out_item_t o;
    o.out_value = cvs_pkg::SUM_BITS'(v);
    o.out_row = cvs_pkg::ROW_BITS'(r);
    o.out_col = cvs_pkg::COL_BITS'(c);
    o.last_of_image = l;
    return o;
  endfunction

  function automatic dir_row_t cfg_row(cvs_pkg::cfg_reg_t idx, int val);
    dir_row_t d;
    d.is_cfg = 1;
    d.idx = idx;
    d.data = val;
    d.it = '0;
    d.typed = 0;
    d.res = '0;
    return d;
  endfunction

  function automatic dir_row_t item_row(bit mode, logic [15:0] v, bit typed = 0,
                                        cvs_pkg::out_item_t res = '0);
    dir_row_t d;
    d.is_cfg = 0;
    d.idx = cvs_pkg::REG_IMAGE_WIDTH;
    d.data = 0;
    d.it = mk(mode, v);
    d.typed = typed;
    d.res = res;
    return d;
  endfunction

  // Drive pop; one long hold-off once a few dozen results have passed
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (!hold_done && n_results >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 26);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    cvs_pkg::out_item_t want;
    if (!rst && pop && !empty) begin
      n_results++;
      if (conv_results_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result: %p", out_item);
      end else begin
        want = conv_results_due.pop_front();
        if (out_item.out_value !== want.out_value || out_item.out_row !== want.out_row ||
            out_item.out_col !== want.out_col ||
            out_item.last_of_image !== want.last_of_image) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("Mismatch: expected value %0d row %0d col %0d last %0b",
                     want.out_value, want.out_row, want.out_col, want.last_of_image);
            $display("          got value %0d row %0d col %0d last %0b",
                     out_item.out_value, out_item.out_row, out_item.out_col,
                     out_item.last_of_image);
          end
        end
      end
    end
  end

  // Run limit
  initial begin
    #20ms;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    dir_row_t rows[$];
    int unsigned w, h, kw, kh, n_img, n_smp;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = cvs_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    push = 1'b0;
    in_item = '0;
    reg_width = 9'd256;
    reg_height = 13'd256;
    reg_kw = 4'd3;
    reg_kh = 4'd3;
    wgt_pos = 0;
    pos_row = 0;
    pos_col = 0;
    foreach (kernel_mem[i]) kernel_mem[i] = '0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    n_items = 0; n_results = 0; n_errors = 0; n_phases = 0;
    calm = 0; hold_done = 0; hold_left = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: 2x2 image, 1x1 kernel, extremes, oversized kernel, zero registers
    rows.push_back(cfg_row(cvs_pkg::REG_IMAGE_WIDTH, 2));
    rows.push_back(cfg_row(cvs_pkg::REG_IMAGE_HEIGHT, 2));
    rows.push_back(cfg_row(cvs_pkg::REG_KERNEL_WIDTH, 1));
    rows.push_back(cfg_row(cvs_pkg::REG_KERNEL_HEIGHT, 1));
    rows.push_back(item_row(0, 16'h7fff));
    rows.push_back(item_row(1, 16'h7fff, 1, mk_res(64'sd1073676289, 0, 0, 0)));
    rows.push_back(item_row(1, 16'h8000, 1, mk_res(-64'sd1073709056, 0, 1, 0)));
    rows.push_back(item_row(1, 16'h0000, 1, mk_res(0, 1, 0, 0)));
    rows.push_back(item_row(1, 16'h0001, 1, mk_res(32767, 1, 1, 1)));
    rows.push_back(item_row(0, 16'h8000));
    rows.push_back(item_row(1, 16'h8000, 1, mk_res(64'sd1073741824, 0, 0, 0)));
    rows.push_back(cfg_row(cvs_pkg::REG_KERNEL_WIDTH, 15));
    rows.push_back(item_row(1, 16'h1234));
    rows.push_back(item_row(1, 16'hffff));
    rows.push_back(cfg_row(cvs_pkg::REG_KERNEL_WIDTH, 0));
    rows.push_back(cfg_row(cvs_pkg::REG_IMAGE_WIDTH, 0));
    rows.push_back(item_row(1, 16'h0100));
    rows.push_back(item_row(1, 16'h00ff));
    rows.push_back(item_row(1, 16'h5a5a));
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        cfg_write(rows[i].idx, rows[i].data);
      end else begin
        send_item(rows[i].it, rows[i].typed, rows[i].res);
      end
    end

    // Random phases: configure, load kernel, stream samples (whole images after the first three phases) with some noise
    while (n_items < ITEM_GOAL) begin
      drain();
      case (n_phases)
        0: begin w = 511; h = 8191; kw = 8; kh = 1; end
        1: begin w = 256; h = 1; kw = 0; kh = 0; end
        2: begin w = 1; h = 0; kw = 1; kh = 1; end
        3: begin w = 8; h = 8; kw = 8; kh = 8; end
        default: begin
          w  = $urandom_range(1, 10);
          h  = $urandom_range(1, 9);
          kw = ($urandom_range(9) == 0) ? 15 : $urandom_range(0, 5);
          kh = ($urandom_range(9) == 0) ? 15 : $urandom_range(0, 5);
        end
      endcase
      cfg_write(cvs_pkg::REG_IMAGE_WIDTH, w);
      cfg_write(cvs_pkg::REG_IMAGE_HEIGHT, h);
      cfg_write(cvs_pkg::REG_KERNEL_WIDTH, kw);
      cfg_write(cvs_pkg::REG_KERNEL_HEIGHT, kh);
      calm = (n_items >= 300 && n_items < 420);
      // first load fills the whole kernel store, later ones only the window
      n_smp = (n_phases == 0) ? cvs_pkg::KERNEL_DEPTH
            : clamp_dim(kw, cvs_pkg::MAX_KERNEL_SIZE) *
              clamp_dim(kh, cvs_pkg::MAX_KERNEL_SIZE);
      repeat (n_smp) send_item(mk(0, rand_value()));
      if (n_phases < 3) begin
        n_smp = 48;
      end else begin
        n_img = $urandom_range(1, 3);
        n_smp = n_img * clamp_dim(w, cvs_pkg::MAX_IMAGE_WIDTH) *
                clamp_dim(h, cvs_pkg::MAX_IMAGE_HEIGHT);
      end
      for (int i = 0; i < n_smp && n_items < ITEM_GOAL; i++) begin
        if ($urandom_range(49) == 0) send_item(mk(0, rand_value()));
        send_item(mk(1, rand_value()));
      end
      n_phases++;
    end

    drain();
    $display("Covered %0d input items and %0d results over %0d configuration phases,",
             n_items, n_results, n_phases);
    $display("including register extremes, oversized kernels and a long result hold-off.");
    if (n_errors == 0 && conv_results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, conv_results_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
